// ----- rtl/ray_box_closest_hit_unit_assert.svh -----
// ============================================================================
// Assertion macros for the ray box closest hit unit
// Shared concurrent check forms, clocked on i_clk and off while in reset.
// ============================================================================
`ifndef RAY_BOX_CLOSEST_HIT_UNIT_ASSERT_SVH
`define RAY_BOX_CLOSEST_HIT_UNIT_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle
`define RBCH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define RBCH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rbch_pkg.sv -----
// ============================================================================
// rbch_pkg
// Shared types and constants of the ray box closest hit unit.
// ============================================================================
package rbch_pkg;

    localparam int COORD_WIDTH_DEF   = 24;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int TAG_WIDTH_DEF     = 16;
    localparam int LAYER_WIDTH       = 32;
    localparam int CFG_INDEX_WIDTH   = 3;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_ORIGIN_X   = 3'd0,
        CFG_ORIGIN_Y   = 3'd1,
        CFG_DIR_X      = 3'd2,
        CFG_DIR_Y      = 3'd3,
        CFG_LAYER_MASK = 3'd4
    } t_cfg_index;

    // Face normal codes
    localparam logic [1:0] NORMAL_POS_X = 2'd0;
    localparam logic [1:0] NORMAL_NEG_X = 2'd1;
    localparam logic [1:0] NORMAL_POS_Y = 2'd2;
    localparam logic [1:0] NORMAL_NEG_Y = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SLAB,
        S_MUL1,
        S_SEL,
        S_MUL2,
        S_TEST,
        S_DIV,
        S_UPD,
        S_FIN,
        S_HMUL,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_box;
        logic slab;
        logic mul1;
        logic sel;
        logic mul2;
        logic test;
        logic div_step;
        logic update;
        logic hmul;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic live;
        logic cand;
        logic div_last;
        logic last;
        logic out_free;
    } t_dp_status;

endpackage

// ----- rtl/rbch_ctrl.sv -----
// ============================================================================
// rbch_ctrl
// Sequencer that walks one box at a time through the slab test, the
// divider and the result stage.
// ============================================================================
module rbch_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  rbch_pkg::t_dp_status  i_status,
    output rbch_pkg::t_dp_cmd     o_cmd
);
    import rbch_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_box = 1'b1;
                    n_state        = S_SLAB;
                end
            end
            S_SLAB: begin
                o_cmd.slab = 1'b1;
                n_state    = S_MUL1;
            end
            S_MUL1: begin
                if (!i_status.live) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.mul1 = 1'b1;
                    n_state    = S_SEL;
                end
            end
            S_SEL: begin
                o_cmd.sel = 1'b1;
                n_state   = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_TEST;
            end
            S_TEST: begin
                o_cmd.test = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                if (!i_status.cand) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (i_status.div_last) begin
                        n_state = S_UPD;
                    end
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                n_state = i_status.last ? S_HMUL : S_IDLE;
            end
            S_HMUL: begin
                o_cmd.hmul = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/rbch_dp.sv -----
// ============================================================================
// rbch_dp
// Datapath: configuration registers, slab fractions, cross-product
// compares, bit-serial divider, closest-hit state and result register.
// ============================================================================
module rbch_dp #(
    parameter int COORD_WIDTH   = rbch_pkg::COORD_WIDTH_DEF,
    parameter int FRACTION_BITS = rbch_pkg::FRACTION_BITS_DEF,
    parameter int TAG_WIDTH     = rbch_pkg::TAG_WIDTH_DEF,
    parameter int CFG_WIDTH     = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [rbch_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  logic [CFG_WIDTH-1:0]                  i_cfg_data,
    input  logic signed [COORD_WIDTH-1:0]         i_box_min_x,
    input  logic signed [COORD_WIDTH-1:0]         i_box_min_y,
    input  logic [COORD_WIDTH-2:0]                i_box_width,
    input  logic [COORD_WIDTH-2:0]                i_box_height,
    input  logic [rbch_pkg::LAYER_WIDTH-1:0]      i_box_layers,
    input  logic [TAG_WIDTH-1:0]                  i_box_id,
    input  logic                                  i_last_box,
    input  rbch_pkg::t_dp_cmd                     i_cmd,
    output rbch_pkg::t_dp_status                  o_status,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_hit,
    output logic [FRACTION_BITS:0]                o_hit_fraction,
    output logic signed [COORD_WIDTH-1:0]         o_hit_x,
    output logic signed [COORD_WIDTH-1:0]         o_hit_y,
    output logic [1:0]                            o_hit_normal,
    output logic [TAG_WIDTH-1:0]                  o_hit_id
);
    import rbch_pkg::*;

    localparam int NW   = COORD_WIDTH + 3;
    localparam int DW   = COORD_WIDTH + 1;
    localparam int PW   = NW + DW + 1;
    localparam int MW   = DW + FRACTION_BITS + 1;
    localparam int SW   = COORD_WIDTH + 3;
    localparam int CNTW = $clog2(FRACTION_BITS);
    localparam logic [FRACTION_BITS:0] ONE_FRAC = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [MW:0] ROUND_UP = (MW+1)'((64'd1 << FRACTION_BITS) - 64'd1);
    localparam logic signed [SW-1:0] CMAX = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] CMIN = -CMAX - SW'(1);

    // Configuration registers
    logic signed [COORD_WIDTH-1:0] r_origin_x, r_origin_y;
    logic signed [COORD_WIDTH:0]   r_dir_x, r_dir_y;
    logic [LAYER_WIDTH-1:0]        r_layer_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x   <= '0;
            r_origin_y   <= '0;
            r_dir_x      <= '0;
            r_dir_y      <= '0;
            r_layer_mask <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_X:   r_origin_x   <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_ORIGIN_Y:   r_origin_y   <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_DIR_X:      r_dir_x      <= i_cfg_data[COORD_WIDTH:0];
                CFG_DIR_Y:      r_dir_y      <= i_cfg_data[COORD_WIDTH:0];
                CFG_LAYER_MASK: r_layer_mask <= i_cfg_data[LAYER_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Capture the box
    logic signed [COORD_WIDTH-1:0] r_bx, r_by;
    logic [COORD_WIDTH-2:0]        r_bw, r_bh;
    logic [LAYER_WIDTH-1:0]        r_layers;
    logic [TAG_WIDTH-1:0]          r_tag;
    logic                          r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_box) begin
            r_bx     <= i_box_min_x;
            r_by     <= i_box_min_y;
            r_bw     <= i_box_width;
            r_bh     <= i_box_height;
            r_layers <= i_box_layers;
            r_tag    <= i_box_id;
            r_last   <= i_last_box;
        end
    end

    // Direction magnitudes and signs
    logic          dx_neg, dy_neg, dx_zero, dy_zero;
    logic [DW-1:0] den_x, den_y;

    assign dx_neg  = r_dir_x[COORD_WIDTH];
    assign dy_neg  = r_dir_y[COORD_WIDTH];
    assign dx_zero = (r_dir_x == '0);
    assign dy_zero = (r_dir_y == '0);
    assign den_x   = dx_neg ? DW'(-r_dir_x) : DW'(r_dir_x);
    assign den_y   = dy_neg ? DW'(-r_dir_y) : DW'(r_dir_y);

    // Slab entry and exit numerators per axis
    logic signed [NW-1:0] ox, oy, lo_x, lo_y, hi_x, hi_y;
    logic signed [NW-1:0] near_x, far_x, near_y, far_y;
    logic                 ok_x, ok_y;

    assign ox     = NW'(r_origin_x);
    assign oy     = NW'(r_origin_y);
    assign lo_x   = NW'(r_bx);
    assign lo_y   = NW'(r_by);
    assign hi_x   = lo_x + NW'($signed({1'b0, r_bw}));
    assign hi_y   = lo_y + NW'($signed({1'b0, r_bh}));
    assign near_x = dx_neg ? (ox - hi_x) : (lo_x - ox);
    assign far_x  = dx_neg ? (ox - lo_x) : (hi_x - ox);
    assign near_y = dy_neg ? (oy - hi_y) : (lo_y - oy);
    assign far_y  = dy_neg ? (oy - lo_y) : (hi_y - oy);
    assign ok_x   = !dx_zero || ((ox >= lo_x) && (ox <= hi_x));
    assign ok_y   = !dy_zero || ((oy >= lo_y) && (oy <= hi_y));

    logic signed [NW-1:0] r_nx, r_fx, r_ny, r_fy;
    logic [DW-1:0]        r_denx, r_deny;
    logic                 r_infx, r_infy, r_live;

    always_ff @(posedge i_clk) begin
        if (i_cmd.slab) begin
            r_nx   <= near_x;
            r_fx   <= far_x;
            r_ny   <= near_y;
            r_fy   <= far_y;
            r_denx <= den_x;
            r_deny <= den_y;
            r_infx <= dx_zero;
            r_infy <= dy_zero;
            r_live <= !(dx_zero && dy_zero) && (|(r_layers & r_layer_mask)) && ok_x && ok_y;
        end
    end

    // Cross products for near and far compares
    logic signed [PW-1:0] r_pa, r_pb, r_pc, r_pd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_pa <= r_nx * $signed({1'b0, r_deny});
            r_pb <= r_ny * $signed({1'b0, r_denx});
            r_pc <= r_fx * $signed({1'b0, r_deny});
            r_pd <= r_fy * $signed({1'b0, r_denx});
        end
    end

    // Pick entry (later near) and exit (earlier far)
    logic xface, exit_from_x;

    assign xface       = r_infx ? 1'b0 : (r_infy ? 1'b1 : (r_pa > r_pb));
    assign exit_from_x = r_infx ? 1'b0 : (r_infy ? 1'b1 : (r_pc < r_pd));

    logic signed [NW-1:0] r_enter_num, r_exit_num;
    logic [DW-1:0]        r_enter_den, r_exit_den;
    logic                 r_xface;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sel) begin
            r_xface     <= xface;
            r_enter_num <= xface ? r_nx : r_ny;
            r_enter_den <= xface ? r_denx : r_deny;
            r_exit_num  <= exit_from_x ? r_fx : r_fy;
            r_exit_den  <= exit_from_x ? r_denx : r_deny;
        end
    end

    // Entry against exit
    logic signed [PW-1:0] r_pe, r_pf;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul2) begin
            r_pe <= r_enter_num * $signed({1'b0, r_exit_den});
            r_pf <= r_exit_num * $signed({1'b0, r_enter_den});
        end
    end

    // Candidate test and divider
    logic                     cand;
    logic                     r_cand;
    logic [DW:0]              r_rem;
    logic [DW:0]              rem2;
    logic [FRACTION_BITS-1:0] r_quot;
    logic [CNTW-1:0]          r_cnt;

    assign cand = (r_exit_num >= 0) && (r_pe <= r_pf) && (r_enter_num >= 0)
                && (r_enter_num < $signed({1'b0, r_enter_den}));
    assign rem2 = {r_rem[DW-1:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand <= 1'b0;
        end else if (i_cmd.test) begin
            r_cand <= cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.test) begin
            r_rem  <= r_enter_num[DW:0];
            r_quot <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.div_step) begin
            // One quotient bit per cycle
            if (rem2 >= {1'b0, r_enter_den}) begin
                r_rem  <= rem2 - {1'b0, r_enter_den};
                r_quot <= {r_quot[FRACTION_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= rem2;
                r_quot <= {r_quot[FRACTION_BITS-2:0], 1'b0};
            end
            r_cnt <= r_cnt + CNTW'(1);
        end
    end

    // Closest hit state
    logic [FRACTION_BITS:0] r_best_fraction;
    logic                   r_any_hit;
    logic [1:0]             r_best_normal;
    logic [TAG_WIDTH-1:0]   r_best_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_fraction <= ONE_FRAC;
            r_any_hit       <= 1'b0;
            r_best_normal   <= NORMAL_POS_X;
            r_best_tag      <= '0;
        end else if (i_cmd.emit) begin
            r_best_fraction <= ONE_FRAC;
            r_any_hit       <= 1'b0;
            r_best_normal   <= NORMAL_POS_X;
            r_best_tag      <= '0;
        end else if (i_cmd.update && ({1'b0, r_quot} < r_best_fraction)) begin
            r_best_fraction <= {1'b0, r_quot};
            r_any_hit       <= 1'b1;
            r_best_tag      <= r_tag;
            if (r_xface) begin
                r_best_normal <= dx_neg ? NORMAL_POS_X : NORMAL_NEG_X;
            end else begin
                r_best_normal <= dy_neg ? NORMAL_POS_Y : NORMAL_NEG_Y;
            end
        end
    end

    // Hit point offsets
    logic [MW-1:0] r_mx, r_my;

    always_ff @(posedge i_clk) begin
        if (i_cmd.hmul) begin
            r_mx <= MW'(den_x) * MW'(r_best_fraction);
            r_my <= MW'(den_y) * MW'(r_best_fraction);
        end
    end

    logic [MW:0]          up_x, up_y;
    logic signed [SW-1:0] off_x, off_y, sum_x, sum_y, sat_x, sat_y;

    assign up_x  = {1'b0, r_mx} + ROUND_UP;
    assign up_y  = {1'b0, r_my} + ROUND_UP;
    assign off_x = dx_neg ? -SW'({1'b0, up_x[MW:FRACTION_BITS]})
                          : SW'({1'b0, r_mx[MW-1:FRACTION_BITS]});
    assign off_y = dy_neg ? -SW'({1'b0, up_y[MW:FRACTION_BITS]})
                          : SW'({1'b0, r_my[MW-1:FRACTION_BITS]});
    assign sum_x = SW'(r_origin_x) + off_x;
    assign sum_y = SW'(r_origin_y) + off_y;
    assign sat_x = (sum_x > CMAX) ? CMAX : ((sum_x < CMIN) ? CMIN : sum_x);
    assign sat_y = (sum_y > CMAX) ? CMAX : ((sum_y < CMIN) ? CMIN : sum_y);

    // Result register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_hit          <= r_any_hit;
            o_hit_fraction <= r_any_hit ? r_best_fraction : ONE_FRAC;
            o_hit_x        <= r_any_hit ? sat_x[COORD_WIDTH-1:0] : '0;
            o_hit_y        <= r_any_hit ? sat_y[COORD_WIDTH-1:0] : '0;
            o_hit_normal   <= r_any_hit ? r_best_normal : NORMAL_POS_X;
            o_hit_id       <= r_any_hit ? r_best_tag : '0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status.live     = r_live;
    assign o_status.cand     = r_cand;
    assign o_status.div_last = (r_cnt == CNTW'(FRACTION_BITS - 1));
    assign o_status.last     = r_last;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    `include "ray_box_closest_hit_unit_assert.svh"

    `RBCH_ASSERT_NOW(a_best_in_range, 1'b1, r_best_fraction <= ONE_FRAC, "best fraction above one")
    `RBCH_ASSERT_NOW(a_no_hit_full, !r_any_hit, r_best_fraction == ONE_FRAC, "best set without hit")
    `RBCH_ASSERT_NEXT(a_emit_clears, i_cmd.emit, !r_any_hit && r_out_valid, "emit left hit state")

endmodule

// ----- rtl/ray_box_closest_hit_unit.sv -----
// ============================================================================
// ray_box_closest_hit_unit
// Casts a ray segment against a stream of boxes with a 2D slab test and
// reports the closest hit when the last box of a cast arrives.
// ============================================================================
//
//  Channel   Dir  Handshake              Payload
//  s_axis    in   tvalid/tready          tdata: boxes; tlast: last box of cast
//  m_axis    out  tvalid/tready          tdata: hit data; tuser: hit flag
//  cfg       in   we (no back-pressure)  index, data: ray and layer mask
//
//  A box that is masked or ruled out by one axis ends after the slab stage;
//  one that misses after the slab compare ends after the candidate test;
//  one that enters within the ray also runs the one-bit-per-cycle fraction
//  divider and the update. The last box adds the hit point and result load.
//  Reset is synchronous, active low; no clearing pass is needed.
//  A result waits in the output register; the next cast proceeds until its
//  own result finds that register still full.
//
module ray_box_closest_hit_unit #(
    parameter int COORD_WIDTH   = rbch_pkg::COORD_WIDTH_DEF,
    parameter int FRACTION_BITS = rbch_pkg::FRACTION_BITS_DEF,
    parameter int TAG_WIDTH     = rbch_pkg::TAG_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // box_min_x, box_min_y, box_width, box_height, box_layers, box_id
    input  logic [((4*COORD_WIDTH+30+TAG_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    input  logic i_s_axis_tlast,
    // hit_fraction, hit_x, hit_y, hit_normal, hit_id
    output logic [((FRACTION_BITS+2*COORD_WIDTH+3+TAG_WIDTH+7)/8)*8-1:0] o_m_axis_tdata,
    // hit
    output logic o_m_axis_tuser,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    input  logic i_cfg_we,
    input  logic [rbch_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [((COORD_WIDTH+1 > 32) ? COORD_WIDTH+1 : 32)-1:0] i_cfg_data
);
    import rbch_pkg::*;

    localparam int CFG_WIDTH = (COORD_WIDTH + 1 > 32) ? COORD_WIDTH + 1 : 32;
    localparam int OUT_W     = ((FRACTION_BITS + 2*COORD_WIDTH + 3 + TAG_WIDTH + 7) / 8) * 8;
    localparam int OFF_MINY  = COORD_WIDTH;
    localparam int OFF_W     = 2 * COORD_WIDTH;
    localparam int OFF_H     = 3 * COORD_WIDTH - 1;
    localparam int OFF_L     = 4 * COORD_WIDTH - 2;
    localparam int OFF_ID    = OFF_L + LAYER_WIDTH;

    t_dp_cmd    cmd;
    t_dp_status status;

    logic                          hit;
    logic [FRACTION_BITS:0]        hit_fraction;
    logic signed [COORD_WIDTH-1:0] hit_x, hit_y;
    logic [1:0]                    hit_normal;
    logic [TAG_WIDTH-1:0]          hit_id;

    rbch_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rbch_dp #(
        .COORD_WIDTH   (COORD_WIDTH),
        .FRACTION_BITS (FRACTION_BITS),
        .TAG_WIDTH     (TAG_WIDTH),
        .CFG_WIDTH     (CFG_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_box_min_x    (i_s_axis_tdata[COORD_WIDTH-1:0]),
        .i_box_min_y    (i_s_axis_tdata[OFF_MINY +: COORD_WIDTH]),
        .i_box_width    (i_s_axis_tdata[OFF_W +: COORD_WIDTH-1]),
        .i_box_height   (i_s_axis_tdata[OFF_H +: COORD_WIDTH-1]),
        .i_box_layers   (i_s_axis_tdata[OFF_L +: LAYER_WIDTH]),
        .i_box_id       (i_s_axis_tdata[OFF_ID +: TAG_WIDTH]),
        .i_last_box     (i_s_axis_tlast),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .o_hit          (hit),
        .o_hit_fraction (hit_fraction),
        .o_hit_x        (hit_x),
        .o_hit_y        (hit_y),
        .o_hit_normal   (hit_normal),
        .o_hit_id       (hit_id)
    );

    // Pack the result transaction
    assign o_m_axis_tdata = OUT_W'({hit_id, hit_normal, hit_y, hit_x, hit_fraction});
    assign o_m_axis_tuser = hit;

endmodule
